/* hw/rtl/mahd_pkg.sv */
// ----------------------------------------------------------------------------
// MPEG audio header decoder package
// Bitrate table, rate constants, divider constants and result field layout.
// ----------------------------------------------------------------------------
package mahd_pkg;

  // Result transaction layout on m_tdata, from bit 0 up
  localparam int F_VALID_LSB  = 0;
  localparam int F_STYPE_LSB  = 1;
  localparam int F_MONO_LSB   = 2;
  localparam int F_RATE_LSB   = 3;
  localparam int F_RATE_W     = 16;
  localparam int F_BPS_LSB    = 19;
  localparam int F_BPS_W      = 19;
  localparam int F_FRAME_LSB  = 38;
  localparam int F_FRAME_W    = 11;
  localparam int F_SCAN_LSB   = 49;
  localparam int F_SCAN_W     = 11;
  localparam int F_SPF_LSB    = 60;
  localparam int F_SPF_W      = 11;
  localparam int F_BURST_LSB  = 71;
  localparam int F_BURST_W    = 4;
  localparam int F_MATCH_LSB  = 75;
  localparam int OUT_BITS     = 76;
  localparam int OUT_W        = 80;
  localparam int IN_W         = 64;

  localparam logic [7:0] SYNC_BYTE  = 8'hff;
  localparam logic [10:0] FREE_SCAN = 11'd1728;
  localparam logic [10:0] SPF_L1    = 11'd384;
  localparam logic [10:0] SPF_L23   = 11'd1152;

  localparam logic [3:0] BURST_MPEG1_L1  = 4'h4;
  localparam logic [3:0] BURST_MPEG1_L23 = 4'h5;
  localparam logic [3:0] BURST_LSF_L1    = 4'h8;
  localparam logic [3:0] BURST_LSF_L23   = 4'h9;

  // Reciprocal shift for the constant divide
  localparam int RECIP_SH = 20;

  // kbit/s by [lsf][layer-1][bitrate index]
  localparam logic [8:0] KBPS_TAB [0:1][0:2][0:15] = '{
    '{'{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}},
    '{'{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}}
  };

  // Sync test: a is the 0xff byte, b the sync/layer byte, c the rate byte
  function automatic logic sync_ok(input logic [7:0] a, input logic [7:0] b,
                                   input logic [7:0] c);
    sync_ok = (a == SYNC_BYTE) && (b[7:4] == 4'hf) && (b[2:1] != 2'b00) &&
              (c[7:4] != 4'hf) && (c[3:2] != 2'b11);
  endfunction

  function automatic logic [15:0] rate_hz(input logic lsf, input logic [1:0] sidx);
    logic [15:0] r;
    case ({lsf, sidx})
      3'b000:  r = 16'd44100;
      3'b001:  r = 16'd48000;
      3'b010:  r = 16'd32000;
      3'b100:  r = 16'd22050;
      3'b101:  r = 16'd24000;
      3'b110:  r = 16'd16000;
      default: r = 16'd0;
    endcase
    rate_hz = r;
  endfunction

  // frame = floor(kbps * k / d): k folds slots and the 1000/rate scale
  function automatic logic [8:0] div_val(input logic lsf, input logic [1:0] sidx);
    logic [8:0] d;
    case ({lsf, sidx})
      3'b000:  d = 9'd441;
      3'b001:  d = 9'd48;
      3'b010:  d = 9'd32;
      3'b100:  d = 9'd441;
      3'b101:  d = 9'd24;
      3'b110:  d = 9'd16;
      default: d = 9'd1;
    endcase
    div_val = d;
  endfunction

  // floor(2^RECIP_SH / d)
  function automatic logic [16:0] recip_val(input logic lsf, input logic [1:0] sidx);
    logic [16:0] r;
    case ({lsf, sidx})
      3'b000:  r = 17'd2377;
      3'b001:  r = 17'd21845;
      3'b010:  r = 17'd32768;
      3'b100:  r = 17'd2377;
      3'b101:  r = 17'd43690;
      3'b110:  r = 17'd65536;
      default: r = 17'd0;
    endcase
    recip_val = r;
  endfunction

  function automatic logic [11:0] k_val(input logic lsf, input logic l1,
                                        input logic [1:0] sidx);
    logic [11:0] k;
    if (sidx == 2'd0) begin
      case ({lsf, l1})
        2'b00:   k = 12'd1440;
        2'b01:   k = 12'd120;
        2'b10:   k = 12'd2880;
        default: k = 12'd240;
      endcase
    end else begin
      k = l1 ? 12'd12 : 12'd144;
    end
    k_val = k;
  endfunction

endpackage

/* hw/rtl/mpeg_audio_header_decoder.sv */
// ----------------------------------------------------------------------------
// MPEG audio header decoder
// Checks a 4-byte candidate for an MPEG-1/LSF audio sync word and decodes it.
// ----------------------------------------------------------------------------
// Slave stream: one transaction carries the four candidate header bytes and
// the four reference header bytes. Master stream: one transaction per input
// with the decoded header (valid flag, stream type, mono, rate, bitrate,
// frame size, free-format scan size, samples per frame, S/PDIF burst type and
// reference match). An invalid header gives an all-zero result.
// Five registered stages advance together: decode and table
// lookup, bitrate/numerator multiply, reciprocal multiply, back
// multiply, then remainder correction into the output register.
// Throughput is one transaction per cycle while the receiver does not stall.
// When the receiver stalls with a result held, the whole pipeline freezes
// and s_tready drops in the same cycle; nothing is lost or repeated.
// Reset (rst, synchronous, active high) clears all stage valid bits; no
// results are pending afterwards and the block is ready at once.
// ----------------------------------------------------------------------------
module mpeg_audio_header_decoder
  import mahd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  // hdr_byte0..3, ref_byte0..3
  input  logic [IN_W-1:0]   s_tdata,
  output logic              m_tvalid,
  input  logic              m_tready,
  // header_valid, stream_type, is_mono, sample_rate_hz, bitrate_bps,
  // frame_bytes, scan_bytes, samples_per_frame, burst_type, headers_match
  output logic [OUT_W-1:0]  m_tdata
);

  typedef struct packed {
    logic        hv;
    logic        swap;
    logic        mono;
    logic [15:0] rate;
    logic [18:0] bps;
    logic        pad;
    logic        l1;
    logic        lsf;
    logic        free;
    logic        match;
  } info_t;

  logic ce;
  assign ce       = !m_tvalid || m_tready;
  assign s_tready = ce;

  // ---------------- stage 1: sync search and field decode ----------------
  logic [7:0] h0, h1, h2, h3, r0, r1, r2, r3;
  logic       sync_be, sync_le, hv, swap;
  logic [7:0] vb, cb, mb, rcb, rmb;
  logic [1:0] lidx;
  logic       l1, lsf;
  logic [3:0] bidx;
  logic [1:0] sidx;
  info_t      info1;

  assign {r3, r2, r1, r0, h3, h2, h1, h0} = s_tdata;

  always_comb begin
    sync_be = sync_ok(h0, h1, h2);
    sync_le = sync_ok(h1, h0, h3);
    hv      = sync_be || sync_le;
    swap    = !sync_be && sync_le;
    vb      = swap ? h0 : h1;
    cb      = swap ? h3 : h2;
    mb      = swap ? h2 : h3;
    rcb     = swap ? r3 : r2;
    rmb     = swap ? r2 : r3;
    lsf     = !vb[3];
    lidx    = (vb[2:1] == 2'b00) ? 2'd0 : 2'd3 - vb[2:1];
    l1      = (lidx == 2'd0);
    bidx    = cb[7:4];
    sidx    = cb[3:2];

    info1.hv    = hv;
    info1.swap  = swap;
    info1.mono  = (mb[7:6] == 2'b11);
    info1.rate  = rate_hz(lsf, sidx);
    info1.bps   = '0;
    info1.pad   = cb[1];
    info1.l1    = l1;
    info1.lsf   = lsf;
    info1.free  = (bidx == 4'd0);
    info1.match = (h0 == r0) && (h1 == r1) && (cb[3:2] == rcb[3:2]) &&
                  ((mb[7:6] == 2'b11) == (rmb[7:6] == 2'b11));
  end

  logic        v1;
  info_t       s1_info;
  logic [8:0]  s1_kbps;
  logic [11:0] s1_k;
  logic [8:0]  s1_div;
  logic [16:0] s1_recip;

  always_ff @(posedge clk) begin
    if (ce) begin
      s1_info  <= info1;
      s1_kbps  <= KBPS_TAB[lsf][lidx][bidx];
      s1_k     <= k_val(lsf, l1, sidx);
      s1_div   <= div_val(lsf, sidx);
      s1_recip <= recip_val(lsf, sidx);
    end
  end

  // ---------------- stage 2: bitrate and numerator ----------------
  logic        v2;
  info_t       s2_info;
  info_t       s2_info_next;
  logic [19:0] s2_x;
  logic [8:0]  s2_div;
  logic [16:0] s2_recip;
  logic [20:0] bps_full;
  logic [20:0] x_full;

  assign bps_full = 21'(s1_kbps) * 21'd1000;
  assign x_full   = 21'(s1_kbps) * 21'(s1_k);

  always_comb begin
    s2_info_next     = s1_info;
    s2_info_next.bps = bps_full[18:0];
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      s2_info  <= s2_info_next;
      s2_x     <= x_full[19:0];
      s2_div   <= s1_div;
      s2_recip <= s1_recip;
    end
  end

  // ---------------- stage 3: quotient estimate ----------------
  logic        v3;
  info_t       s3_info;
  logic [19:0] s3_x;
  logic [8:0]  s3_div;
  logic [10:0] s3_q0;
  logic [36:0] qprod;

  assign qprod = 37'(s2_x) * 37'(s2_recip);

  always_ff @(posedge clk) begin
    if (ce) begin
      s3_info <= s2_info;
      s3_x    <= s2_x;
      s3_div  <= s2_div;
      s3_q0   <= qprod[RECIP_SH +: 11];
    end
  end

  // ---------------- stage 4: back multiply ----------------
  logic        v4;
  info_t       s4_info;
  logic [19:0] s4_x;
  logic [8:0]  s4_div;
  logic [10:0] s4_q0;
  logic [19:0] s4_qd;
  logic [19:0] qd_full;

  assign qd_full = 20'(s3_q0) * 20'(s3_div);

  always_ff @(posedge clk) begin
    if (ce) begin
      s4_info <= s3_info;
      s4_x    <= s3_x;
      s4_div  <= s3_div;
      s4_q0   <= s3_q0;
      s4_qd   <= qd_full;
    end
  end

  // ---------------- stage 5: correction and output ----------------
  logic [19:0] rem;
  logic [11:0] q_pad;
  logic [13:0] frame_full;
  logic [10:0] frame_next;

  always_comb begin
    // estimate is low by at most one
    rem        = s4_x - s4_qd;
    q_pad      = 12'(s4_q0) + ((rem >= 20'(s4_div)) ? 12'd1 : 12'd0) +
                 12'(s4_info.pad);
    frame_full = s4_info.l1 ? {q_pad, 2'b00} : {2'b00, q_pad};
    frame_next = s4_info.free ? 11'd0 : frame_full[10:0];
  end

  logic        o_hv, o_swap, o_mono, o_match;
  logic [15:0] o_rate;
  logic [18:0] o_bps;
  logic [10:0] o_frame, o_scan, o_spf;
  logic [3:0]  o_burst;

  always_ff @(posedge clk) begin
    if (ce) begin
      if (s4_info.hv) begin
        o_hv    <= 1'b1;
        o_swap  <= s4_info.swap;
        o_mono  <= s4_info.mono;
        o_rate  <= s4_info.rate;
        o_bps   <= s4_info.bps;
        o_frame <= frame_next;
        o_scan  <= s4_info.free ? FREE_SCAN : 11'd0;
        o_spf   <= s4_info.l1 ? SPF_L1 : SPF_L23;
        if (s4_info.lsf) begin
          o_burst <= s4_info.l1 ? BURST_LSF_L1 : BURST_LSF_L23;
        end else begin
          o_burst <= s4_info.l1 ? BURST_MPEG1_L1 : BURST_MPEG1_L23;
        end
        o_match <= s4_info.match;
      end else begin
        o_hv    <= 1'b0;
        o_swap  <= 1'b0;
        o_mono  <= 1'b0;
        o_rate  <= '0;
        o_bps   <= '0;
        o_frame <= '0;
        o_scan  <= '0;
        o_spf   <= '0;
        o_burst <= '0;
        o_match <= 1'b0;
      end
    end
  end

  // stage valid bits
  logic v5;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (ce) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  assign m_tvalid = v5;
  assign m_tdata  = {{(OUT_W - OUT_BITS){1'b0}}, o_match, o_burst, o_spf, o_scan,
                     o_frame, o_bps, o_rate, o_mono, o_swap, o_hv};

endmodule

/* hw/rtl/mahd_checker.sv */
// ----------------------------------------------------------------------------
// MPEG audio header decoder port checker
// Watches the stream ports of the decoder; attached by bind.
// ----------------------------------------------------------------------------
module mahd_checker
  import mahd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             s_tready,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  logic [F_SPF_W-1:0] spf;
  assign spf = m_tdata[F_SPF_LSB +: F_SPF_W];

  // held result stays put while the receiver stalls
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // invalid header means an all-zero result
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[F_VALID_LSB] |-> (m_tdata[OUT_W-1:1] == '0))
    else $error("invalid header with nonzero fields");

  a_spf: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[F_VALID_LSB] |-> (spf == SPF_L1) || (spf == SPF_L23))
    else $error("bad samples per frame");

  // input is taken exactly when the output slot is free or draining
  a_ready: assert property (@(posedge clk) disable iff (rst)
    s_tready == (!m_tvalid || m_tready))
    else $error("ready does not follow output stall");

  a_reset: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid right after reset");

endmodule

bind mpeg_audio_header_decoder mahd_checker u_mahd_checker (.*);

/* verif/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// MPEG audio header decoder testbench
// Drives header/reference byte sets with random idling on both streams,
// predicts each decoded header and checks every result transaction in order.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int          RANDOM_ITEMS = 1500;
  localparam int          DRAIN_CYCLES = 12;

  // kbit/s by [lsf][layer index][bitrate index]
  localparam int unsigned KBPS [0:1][0:2][0:15] = '{
    '{'{0, 32, 64, 96, 128, 160, 192, 224, 256, 288, 320, 352, 384, 416, 448, 0},
      '{0, 32, 48, 56,  64,  80,  96, 112, 128, 160, 192, 224, 256, 320, 384, 0},
      '{0, 32, 40, 48,  56,  64,  80,  96, 112, 128, 160, 192, 224, 256, 320, 0}},
    '{'{0, 32, 48, 56,  64,  80,  96, 112, 128, 144, 160, 176, 192, 224, 256, 0},
      '{0,  8, 16, 24,  32,  40,  48,  56,  64,  80,  96, 112, 128, 144, 160, 0},
      '{0,  8, 16, 24,  32,  40,  48,  56,  64,  80,  96, 112, 128, 144, 160, 0}}
  };
  localparam int unsigned RATE_HZ [0:1][0:3] = '{
    '{44100, 48000, 32000, 0},
    '{22050, 24000, 16000, 0}
  };
  localparam int unsigned SLOTS [0:2] = '{12, 144, 144};

  typedef struct packed {
    logic        valid;
    logic        le;
    logic        mono;
    logic [15:0] rate;
    logic [18:0] bps;
    logic [10:0] frame;
    logic [10:0] scan;
    logic [10:0] spf;
    logic [3:0]  burst;
    logic        match;
  } hdr_info_t;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [mahd_pkg::IN_W-1:0]     s_tdata  = '0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [mahd_pkg::OUT_W-1:0]    m_tdata;

  hdr_info_t      pending_decodes [$];
  logic [63:0]    pending_items [$];
  hdr_info_t      want;
  hdr_info_t      got;
  logic [63:0]    want_item;
  int             mismatches   = 0;
  int unsigned    stall_cycles = 0;
  logic           steady_flow  = 1'b0;

  mpeg_audio_header_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // a: 0xff byte, b: sync/layer byte, c: rate byte
  function automatic bit sync_found(input logic [7:0] a, input logic [7:0] b,
                                    input logic [7:0] c);
    return a == 8'hff && b[7:4] == 4'hf && b[2:1] != 2'b00 &&
           c[7:4] != 4'hf && c[3:2] != 2'b11;
  endfunction

  function automatic hdr_info_t decode_header(input logic [63:0] item);
    hdr_info_t   d;
    logic [7:0]  h [4];
    logic [7:0]  r [4];
    logic        le;
    logic [31:0] w;
    int unsigned ver, layer, bidx, sidx, rate, bps, fsize, scan;
    d = '0;
    for (int i = 0; i < 4; i++) begin
      h[i] = item[8*i +: 8];
      r[i] = item[32 + 8*i +: 8];
    end
    // big-endian form wins when both forms sync
    if (sync_found(h[0], h[1], h[2]))
      le = 1'b0;
    else if (sync_found(h[1], h[0], h[3]))
      le = 1'b1;
    else
      return d;
    w = le ? {h[1], h[0], h[3], h[2]} : {h[0], h[1], h[2], h[3]};
    ver   = w[19] ? 0 : 1;
    layer = 3 - w[18:17];
    bidx  = w[15:12];
    sidx  = w[11:10];
    rate  = RATE_HZ[ver][sidx];
    bps   = KBPS[ver][layer][bidx] * 1000;
    if (bps != 0 && rate != 0) begin
      fsize = bps * SLOTS[layer] / rate + w[9];
      scan  = 0;
    end else begin
      fsize = 0;
      scan  = mahd_pkg::FREE_SCAN;
    end
    if (layer == 0)
      fsize = fsize * 4;
    d.valid = 1'b1;
    d.le    = le;
    d.mono  = w[7:6] == 2'b11;
    d.rate  = 16'(rate);
    d.bps   = 19'(bps);
    d.frame = 11'(fsize);
    d.scan  = 11'(scan);
    d.spf   = (layer == 0) ? mahd_pkg::SPF_L1 : mahd_pkg::SPF_L23;
    if (ver != 0)
      d.burst = (layer == 0) ? mahd_pkg::BURST_LSF_L1 : mahd_pkg::BURST_LSF_L23;
    else
      d.burst = (layer == 0) ? mahd_pkg::BURST_MPEG1_L1 : mahd_pkg::BURST_MPEG1_L23;
    // reference is read in the candidate's byte order; modes 0..2 are all stereo
    if (le)
      d.match = h[1] == r[1] && h[0] == r[0] && h[3][3:2] == r[3][3:2] &&
                ((h[2][7:6] == 2'b11) == (r[2][7:6] == 2'b11));
    else
      d.match = h[0] == r[0] && h[1] == r[1] && h[2][3:2] == r[2][3:2] &&
                ((h[3][7:6] == 2'b11) == (r[3][7:6] == 2'b11));
    return d;
  endfunction

  // Header in stream order, byte 0 in the low bits; le swaps each byte pair
  function automatic logic [31:0] pack_header(input logic id, input logic [1:0] lay,
                                              input logic [3:0] bidx,
                                              input logic [1:0] sidx, input logic pad,
                                              input logic [1:0] mode, input logic le);
    logic [7:0] noise, b1, b2, b3;
    noise = 8'($urandom);
    b1 = {4'hf, id, lay, noise[0]};
    b2 = {bidx, sidx, pad, noise[1]};
    b3 = {mode, noise[7:2]};
    return le ? {b2, b3, 8'hff, b1} : {b3, b2, b1, 8'hff};
  endfunction

  function automatic logic [31:0] make_reference(input logic [31:0] hdr, input logic le);
    logic [31:0] r, mask;
    int unsigned pick, idx;
    pick = $urandom_range(0, 9);
    r = hdr;
    if (pick >= 8) begin
      r = $urandom;
    end else if (pick >= 6) begin
      idx = $urandom_range(0, 31);
      r[idx] = ~r[idx];
    end else if (pick >= 3) begin
      // scramble the bits that the comparison ignores
      mask = le ? 32'hf33f_0000 : 32'h3ff3_0000;
      r = (hdr & ~mask) | ($urandom & mask);
      if (le && hdr[23:22] != 2'b11)
        r[23:22] = 2'($urandom_range(0, 2));
      if (!le && hdr[31:30] != 2'b11)
        r[31:30] = 2'($urandom_range(0, 2));
    end
    return r;
  endfunction

  function automatic logic [63:0] random_item();
    logic [31:0] h;
    logic [1:0]  lay, sidx;
    logic [3:0]  bidx;
    logic        le;
    int unsigned idx;
    if ($urandom_range(0, 99) < 20)
      return {$urandom, $urandom};
    lay  = ($urandom_range(0, 15) == 0) ? 2'b00 : 2'($urandom_range(1, 3));
    bidx = ($urandom_range(0, 15) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
    sidx = ($urandom_range(0, 11) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
    le   = 1'($urandom_range(0, 1));
    h = pack_header(1'($urandom_range(0, 1)), lay, bidx, sidx,
                    1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)), le);
    if ($urandom_range(0, 19) == 0) begin
      idx = $urandom_range(0, 31);
      return {make_reference(h, le), h ^ (32'h1 << idx)};
    end
    return {make_reference(h, le), h};
  endfunction

  function automatic string info_text(input hdr_info_t d);
    return $sformatf({"valid=%0d le=%0d mono=%0d rate=%0d bps=%0d frame=%0d ",
                      "scan=%0d spf=%0d burst=%0d match=%0d"},
                     d.valid, d.le, d.mono, d.rate, d.bps, d.frame, d.scan,
                     d.spf, d.burst, d.match);
  endfunction

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_header(input logic [63:0] item);
    hdr_info_t d;
    d = decode_header(item);
    while (!steady_flow && $urandom_range(0, 99) < 35) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= item;
    do @(posedge clk); while (!s_tready);
    pending_decodes.push_back(d);
    pending_items.push_back(item);
    @(negedge clk);
  endtask

  task automatic hold_until_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending_decodes.size() != 0);
  endtask

  task automatic test_extreme_values();
    logic [31:0] h;
    send_header('0);
    send_header('1);
    h = pack_header(1'b1, 2'b11, 4'd14, 2'd2, 1'b1, 2'd0, 1'b0);  // L1 448k at 32k, padded
    send_header({h, h});
    h = pack_header(1'b1, 2'b10, 4'd14, 2'd2, 1'b1, 2'd3, 1'b1);  // largest frame
    send_header({h, h});
    h = pack_header(1'b0, 2'b01, 4'd1, 2'd0, 1'b0, 2'd1, 1'b0);   // smallest LSF L3
    send_header({~h, h});
  endtask

  task automatic test_layer_version();
    logic [31:0] h;
    for (int id = 0; id < 2; id++) begin
      for (int lay = 1; lay < 4; lay++) begin
        h = pack_header(id[0], 2'(lay), 4'd9, 2'd0, 1'b1, 2'(lay), lay[0]);
        send_header({make_reference(h, lay[0]), h});
      end
    end
  endtask

  task automatic test_free_format();
    logic [31:0] h;
    h = pack_header(1'b1, 2'b11, 4'd0, 2'd1, 1'b1, 2'd3, 1'b0);
    send_header({h, h});
    h = pack_header(1'b0, 2'b01, 4'd0, 2'd2, 1'b1, 2'd0, 1'b1);
    send_header({h, h});
  endtask

  task automatic test_sync_order();
    // both byte orders sync here: big-endian must be taken
    send_header({32'h5490ffff, 32'h5490ffff});
    // only the swapped order syncs
    send_header({32'h9040fffb, 32'h9040fffb});
  endtask

  task automatic test_bad_headers();
    logic [31:0] h;
    h = pack_header(1'b1, 2'b01, 4'd5, 2'd3, 1'b0, 2'd0, 1'b0);   // reserved rate
    send_header({h, h});
    h = pack_header(1'b1, 2'b01, 4'd15, 2'd0, 1'b0, 2'd0, 1'b1);  // bad bitrate
    send_header({h, h});
    h = pack_header(1'b0, 2'b00, 4'd5, 2'd0, 1'b0, 2'd0, 1'b0);   // reserved layer
    send_header({h, h});
    h = pack_header(1'b1, 2'b10, 4'd5, 2'd0, 1'b0, 2'd0, 1'b0);
    h[15:12] = 4'he;
    send_header({h, h});
    h = pack_header(1'b1, 2'b10, 4'd5, 2'd0, 1'b0, 2'd0, 1'b0);
    h[7:0] = 8'hfe;
    send_header({h, h});
  endtask

  task automatic test_reference_match();
    logic [31:0] h, r;
    h = pack_header(1'b1, 2'b01, 4'd5, 2'd1, 1'b0, 2'd0, 1'b0);
    send_header({h, h});
    r = h;
    r[31:30] = 2'b10;
    send_header({r, h});
    r[31:30] = 2'b11;
    send_header({r, h});
    r = h;
    r[19:18] = ~h[19:18];
    send_header({r, h});
    r = h;
    r[8] = ~h[8];
    send_header({r, h});
    // bitrate differs, not compared
    h = pack_header(1'b0, 2'b10, 4'd5, 2'd1, 1'b0, 2'd3, 1'b1);
    r = h;
    r[31:28] = ~h[31:28];
    send_header({r, h});
  endtask

  task automatic test_random_headers();
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      steady_flow = (i >= 600 && i < 900);
      if (i == 1100)
        hold_until_drained();
      send_header(random_item());
    end
    steady_flow = 1'b0;
  endtask

  always @(negedge clk)
    m_tready <= steady_flow || ($urandom_range(0, 99) >= 35);

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got.valid = m_tdata[mahd_pkg::F_VALID_LSB];
      got.le    = m_tdata[mahd_pkg::F_STYPE_LSB];
      got.mono  = m_tdata[mahd_pkg::F_MONO_LSB];
      got.rate  = m_tdata[mahd_pkg::F_RATE_LSB +: mahd_pkg::F_RATE_W];
      got.bps   = m_tdata[mahd_pkg::F_BPS_LSB +: mahd_pkg::F_BPS_W];
      got.frame = m_tdata[mahd_pkg::F_FRAME_LSB +: mahd_pkg::F_FRAME_W];
      got.scan  = m_tdata[mahd_pkg::F_SCAN_LSB +: mahd_pkg::F_SCAN_W];
      got.spf   = m_tdata[mahd_pkg::F_SPF_LSB +: mahd_pkg::F_SPF_W];
      got.burst = m_tdata[mahd_pkg::F_BURST_LSB +: mahd_pkg::F_BURST_W];
      got.match = m_tdata[mahd_pkg::F_MATCH_LSB];
      if (pending_decodes.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("tb: unexpected result transaction: %s", info_text(got));
      end else begin
        want      = pending_decodes.pop_front();
        want_item = pending_items.pop_front();
        if (got.valid !== want.valid || got.le !== want.le || got.mono !== want.mono ||
            got.rate !== want.rate || got.bps !== want.bps || got.frame !== want.frame ||
            got.scan !== want.scan || got.spf !== want.spf || got.burst !== want.burst ||
            got.match !== want.match) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("tb: mismatch for input %016h", want_item);
            $display("  expected %s", info_text(want));
            $display("  actual   %s", info_text(got));
          end
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either stream
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_extreme_values();
    test_layer_version();
    test_free_format();
    test_sync_order();
    test_bad_headers();
    test_reference_match();
    hold_until_drained();
    test_random_headers();
    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_decodes.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mahd_pkg.sv
hw/rtl/mpeg_audio_header_decoder.sv
hw/rtl/mahd_checker.sv
verif/tb.sv
